### rtl/vvp_pkg.sv
package vvp_pkg;

  // Field widths of the datapath.
  localparam int COORD_W = 32;
  localparam int TRIG_W  = 16;
  localparam int FOCAL_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int YAW_W   = 36;
  localparam int FIN_W   = 39;
  localparam int NX_W    = YAW_W + FOCAL_W + 1;
  localparam int NY_W    = FIN_W + FOCAL_W + 1;
  localparam int SUM_W   = NY_W + 2;
  localparam int TRIG_FRAC = 14;

  // Near plane in Q16.16.
  localparam logic signed [FIN_W-1:0] NEAR_LIMIT = 39'sd6554;

  // Screen defaults.
  localparam int SCREEN_WIDTH_DEF  = 640;
  localparam int SCREEN_HEIGHT_DEF = 480;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 4;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAMERA_X    = 4'd0,
    REG_CAMERA_Y    = 4'd1,
    REG_CAMERA_Z    = 4'd2,
    REG_COS_YAW     = 4'd3,
    REG_SIN_YAW     = 4'd4,
    REG_COS_PITCH   = 4'd5,
    REG_SIN_PITCH   = 4'd6,
    REG_FOCAL_SCALE = 4'd7
  } cfg_reg_t;

  // One rotated vertex, as handed from the front to the back.
  typedef struct packed {
    logic                    vis;
    logic signed [YAW_W-1:0] x_yaw;
    logic signed [FIN_W-1:0] y_fin;
    logic signed [FIN_W-1:0] z_fin;
  } view_word_t;

  // Queue status seen by the top level.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

### rtl/vvp_front.sv
module vvp_front import vvp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      valid_i,
  input  logic signed [COORD_W-1:0] vx_i,
  input  logic signed [COORD_W-1:0] vy_i,
  input  logic signed [COORD_W-1:0] vz_i,
  input  logic signed [COORD_W-1:0] cam_x_i,
  input  logic signed [COORD_W-1:0] cam_y_i,
  input  logic signed [COORD_W-1:0] cam_z_i,
  input  logic signed [TRIG_W-1:0]  cos_yaw_i,
  input  logic signed [TRIG_W-1:0]  sin_yaw_i,
  input  logic signed [TRIG_W-1:0]  cos_pitch_i,
  input  logic signed [TRIG_W-1:0]  sin_pitch_i,
  output logic                      valid_o,
  output view_word_t                word_o
);

  localparam int P1_W = DIFF_W + TRIG_W;
  localparam int S1_W = P1_W + 1;
  localparam int P2_W = YAW_W + TRIG_W;
  localparam int S2_W = P2_W + 1;

  logic [4:0] vld_r;

  logic signed [DIFF_W-1:0] dx_r, dy_r, dz_r, dy1_r, dy2_r;
  logic signed [P1_W-1:0]   p_xc_r, p_zs_r, p_xs_r, p_zc_r;
  logic signed [YAW_W-1:0]  x_yaw_r, x_yaw3_r, z_yaw_r;
  logic signed [P1_W-1:0]   p_yc_r, p_ys_r;
  logic signed [P2_W-1:0]   p_zsp_r, p_zcp_r;
  logic signed [FIN_W-1:0]  y_fin_r, z_fin_r;
  logic signed [YAW_W-1:0]  x_yaw4_r;
  logic [S1_W-1:0]          s_xy, s_zy;
  logic [S2_W-1:0]          s_yp, s_zp;

  // Yaw and pitch sums before the floor shift.
  assign s_xy = {p_xc_r[P1_W-1], p_xc_r} - {p_zs_r[P1_W-1], p_zs_r};
  assign s_zy = {p_xs_r[P1_W-1], p_xs_r} + {p_zc_r[P1_W-1], p_zc_r};
  assign s_yp = {{(S2_W-P1_W){p_yc_r[P1_W-1]}}, p_yc_r} - {p_zsp_r[P2_W-1], p_zsp_r};
  assign s_zp = {{(S2_W-P1_W){p_ys_r[P1_W-1]}}, p_ys_r} + {p_zcp_r[P2_W-1], p_zcp_r};

  // Valid bits of the five stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], valid_i};
    end
  end

  // Stage datapath: offset, yaw products, yaw sums, pitch products, pitch sums.
  always_ff @(posedge clk) begin
    dx_r <= DIFF_W'(vx_i) - DIFF_W'(cam_x_i);
    dy_r <= DIFF_W'(vy_i) - DIFF_W'(cam_y_i);
    dz_r <= DIFF_W'(vz_i) - DIFF_W'(cam_z_i);

    p_xc_r <= dx_r * cos_yaw_i;
    p_zs_r <= dz_r * sin_yaw_i;
    p_xs_r <= dx_r * sin_yaw_i;
    p_zc_r <= dz_r * cos_yaw_i;
    dy1_r  <= dy_r;

    x_yaw_r <= $signed(s_xy[S1_W-1:TRIG_FRAC]);
    z_yaw_r <= $signed(s_zy[S1_W-1:TRIG_FRAC]);
    dy2_r   <= dy1_r;

    p_yc_r   <= dy2_r * cos_pitch_i;
    p_ys_r   <= dy2_r * sin_pitch_i;
    p_zsp_r  <= z_yaw_r * sin_pitch_i;
    p_zcp_r  <= z_yaw_r * cos_pitch_i;
    x_yaw3_r <= x_yaw_r;

    y_fin_r  <= $signed(s_yp[S2_W-1:TRIG_FRAC]);
    z_fin_r  <= $signed(s_zp[S2_W-1:TRIG_FRAC]);
    x_yaw4_r <= x_yaw3_r;
  end

  // Classify against the near plane.
  assign valid_o      = vld_r[4];
  assign word_o.vis   = (z_fin_r > NEAR_LIMIT);
  assign word_o.x_yaw = x_yaw4_r;
  assign word_o.y_fin = y_fin_r;
  assign word_o.z_fin = z_fin_r;

endmodule

### rtl/vvp_queue.sv
module vvp_queue import vvp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_i,
  input  view_word_t  word_i,
  input  logic        pop_i,
  output view_word_t  word_o,
  output queue_stat_t stat_o
);

  // Two-entry queue in flip-flops.
  view_word_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign do_pop  = pop_i && (cnt_r != 2'd0);
  assign do_push = push_i && ((cnt_r != 2'd2) || do_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= word_i;
  end

  assign word_o       = mem_r[rp_r];
  assign stat_o.full  = (cnt_r == 2'd2);
  assign stat_o.empty = (cnt_r == 2'd0);

endmodule

### rtl/vvp_div.sv
module vvp_div #(
  parameter int NW = 56,
  parameter int DW = 39,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [PW-1:0] pay_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_o,
  output logic [PW-1:0] pay_o
);

  // One quotient bit per stage; the numerator shifts out as quotient shifts in.
  logic          vld [NW+1];
  logic [NW-1:0] num [NW+1];
  logic [DW-1:0] rem [NW+1];
  logic [DW-1:0] den [NW+1];
  logic [PW-1:0] pay [NW+1];

  assign vld[0] = valid_i;
  assign num[0] = num_i;
  assign rem[0] = '0;
  assign den[0] = den_i;
  assign pay[0] = pay_i;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW:0] trial;
    logic        qbit;

    assign trial = {rem[k], num[k][NW-1]};
    assign qbit  = (trial >= {1'b0, den[k]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      rem[k+1] <= qbit ? DW'(trial - {1'b0, den[k]}) : DW'(trial);
      num[k+1] <= {num[k][NW-2:0], qbit};
      den[k+1] <= den[k];
      pay[k+1] <= pay[k];
    end
  end

  assign valid_o = vld[NW];
  assign quo_o   = num[NW];
  assign pay_o   = pay[NW];

endmodule

### rtl/vvp_back.sv
module vvp_back import vvp_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      valid_i,
  input  view_word_t                word_i,
  input  logic [FOCAL_W-1:0]        focal_i,
  output logic                      valid_o,
  output logic                      vis_o,
  output logic signed [COORD_W-1:0] sx_o,
  output logic signed [COORD_W-1:0] sy_o
);

  localparam logic signed [SUM_W-1:0] HALF_W = SUM_W'(SCREEN_WIDTH / 2);
  localparam logic signed [SUM_W-1:0] HALF_H = SUM_W'(SCREEN_HEIGHT / 2);
  localparam logic signed [SUM_W-1:0] S32_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] S32_MIN = -SUM_W'(64'sd2147483648);

  logic                   m_vld_r, a_vld_r;
  logic signed [NX_W-1:0] nx_r;
  logic signed [NY_W-1:0] ny_r;
  logic [FIN_W-1:0]       d_r, ad_r;
  logic                   vis_r, avis_r;
  logic [NX_W-1:0]        ax_r;
  logic [NY_W-1:0]        ay_r;
  logic                   negx_r, negy_r;

  logic                   dx_vld, dy_vld;
  logic [NY_W-1:0]        qx;
  logic [NY_W-1:0]        qy;
  logic [1:0]             payx;
  logic                   payy;

  logic signed [SUM_W-1:0] vx, vy, tx, ty;
  logic                    out_vld_r, out_vis_r;
  logic signed [COORD_W-1:0] out_x_r, out_y_r;

  // Valid bits of the multiply, magnitude and output stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r   <= 1'b0;
      a_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      m_vld_r   <= valid_i;
      a_vld_r   <= m_vld_r;
      out_vld_r <= dx_vld && dy_vld;
    end
  end

  // Scale by the focal length, then split sign and magnitude.
  always_ff @(posedge clk) begin
    nx_r  <= word_i.x_yaw * $signed({1'b0, focal_i});
    ny_r  <= word_i.y_fin * $signed({1'b0, focal_i});
    d_r   <= word_i.z_fin;
    vis_r <= word_i.vis;

    ax_r   <= nx_r[NX_W-1] ? NX_W'(-nx_r) : NX_W'(nx_r);
    ay_r   <= ny_r[NY_W-1] ? NY_W'(-ny_r) : NY_W'(ny_r);
    negx_r <= nx_r[NX_W-1];
    negy_r <= ny_r[NY_W-1];
    ad_r   <= d_r;
    avis_r <= vis_r;
  end

  // Both dividers run at the y width so their quotients come out together.
  vvp_div #(.NW(NY_W), .DW(FIN_W), .PW(2)) u_div_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (a_vld_r),
    .num_i   (NY_W'(ax_r)),
    .den_i   (ad_r),
    .pay_i   ({avis_r, negx_r}),
    .valid_o (dx_vld),
    .quo_o   (qx),
    .pay_o   (payx)
  );

  vvp_div #(.NW(NY_W), .DW(FIN_W), .PW(1)) u_div_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (a_vld_r),
    .num_i   (ay_r),
    .den_i   (ad_r),
    .pay_i   (negy_r),
    .valid_o (dy_vld),
    .quo_o   (qy),
    .pay_o   (payy)
  );

  // Restore the sign; the magnitude split makes the quotient truncate toward zero.
  always_comb begin
    vx = payx[0] ? -SUM_W'(qx) : SUM_W'(qx);
    vy = payy    ? -SUM_W'(qy) : SUM_W'(qy);
  end

  // Screen offset, saturation and the clipped case.
  assign tx = vx + HALF_W;
  assign ty = vy + HALF_H;

  always_ff @(posedge clk) begin
    out_vis_r <= payx[1];
    if (!payx[1]) begin
      out_x_r <= '0;
      out_y_r <= '0;
    end else begin
      out_x_r <= (tx > S32_MAX) ? COORD_W'(S32_MAX) :
                 (tx < S32_MIN) ? COORD_W'(S32_MIN) : COORD_W'(tx);
      out_y_r <= (ty > S32_MAX) ? COORD_W'(S32_MAX) :
                 (ty < S32_MIN) ? COORD_W'(S32_MIN) : COORD_W'(ty);
    end
  end

  assign valid_o = out_vld_r;
  assign vis_o   = out_vis_r;
  assign sx_o    = out_x_r;
  assign sy_o    = out_y_r;

endmodule

### rtl/vertex_view_project_unit.sv
// Perspective projection of world vertices through a yaw/pitch camera. A vertex is
// taken whenever start is high and busy is low; busy stays low in normal use, so one
// vertex can enter every clock. Each vertex gives one result, shown for a single cycle
// with out_valid, after five front stages (offset, yaw and pitch rotation), the
// two-entry queue, two scale stages and a 56-stage restoring divider, one quotient
// bit per stage, then one output stage. The receiver cannot stall, so results must
// be taken as they appear. Camera registers are written through the cfg port; the
// user must write them only while no vertex is in flight; the block does not check.
module vertex_view_project_unit import vvp_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] in_vertex_x,
  input  logic signed [COORD_W-1:0] in_vertex_y,
  input  logic signed [COORD_W-1:0] in_vertex_z,
  output logic                      out_valid,
  output logic                      out_visible,
  output logic signed [COORD_W-1:0] out_screen_x,
  output logic signed [COORD_W-1:0] out_screen_y,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [COORD_W-1:0]        cfg_wdata
);

  logic signed [COORD_W-1:0] cam_x_r, cam_y_r, cam_z_r;
  logic signed [TRIG_W-1:0]  cos_yaw_r, sin_yaw_r, cos_pitch_r, sin_pitch_r;
  logic [FOCAL_W-1:0]        focal_r;

  logic        f_valid;
  view_word_t  f_word, q_word;
  queue_stat_t q_stat;
  logic        accept;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r     <= 32'sd327680;
      cam_y_r     <= 32'sd327680;
      cam_z_r     <= -32'sd655360;
      cos_yaw_r   <= 16'sd16384;
      sin_yaw_r   <= 16'sd0;
      cos_pitch_r <= 16'sd16384;
      sin_pitch_r <= 16'sd0;
      focal_r     <= 16'd200;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAMERA_X:    cam_x_r     <= cfg_wdata;
        REG_CAMERA_Y:    cam_y_r     <= cfg_wdata;
        REG_CAMERA_Z:    cam_z_r     <= cfg_wdata;
        REG_COS_YAW:     cos_yaw_r   <= cfg_wdata[TRIG_W-1:0];
        REG_SIN_YAW:     sin_yaw_r   <= cfg_wdata[TRIG_W-1:0];
        REG_COS_PITCH:   cos_pitch_r <= cfg_wdata[TRIG_W-1:0];
        REG_SIN_PITCH:   sin_pitch_r <= cfg_wdata[TRIG_W-1:0];
        REG_FOCAL_SCALE: focal_r     <= cfg_wdata[FOCAL_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy   = q_stat.full;
  assign accept = start && !busy;

  vvp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid_i     (accept),
    .vx_i        (in_vertex_x),
    .vy_i        (in_vertex_y),
    .vz_i        (in_vertex_z),
    .cam_x_i     (cam_x_r),
    .cam_y_i     (cam_y_r),
    .cam_z_i     (cam_z_r),
    .cos_yaw_i   (cos_yaw_r),
    .sin_yaw_i   (sin_yaw_r),
    .cos_pitch_i (cos_pitch_r),
    .sin_pitch_i (sin_pitch_r),
    .valid_o     (f_valid),
    .word_o      (f_word)
  );

  // The back takes one word every cycle, so the queue drains whenever it holds one.
  vvp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (f_valid),
    .word_i (f_word),
    .pop_i  (1'b1),
    .word_o (q_word),
    .stat_o (q_stat)
  );

  vvp_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (!q_stat.empty),
    .word_i  (q_word),
    .focal_i (focal_r),
    .valid_o (out_valid),
    .vis_o   (out_visible),
    .sx_o    (out_screen_x),
    .sy_o    (out_screen_y)
  );

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import vvp_pkg::*;

  localparam int SCR_W = SCREEN_WIDTH_DEF;
  localparam int SCR_H = SCREEN_HEIGHT_DEF;
  localparam int DRAIN_CYCLES = 100;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } vertex_t;

  typedef struct packed {
    logic               vis;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_vertex_x = '0;
  logic signed [31:0] in_vertex_y = '0;
  logic signed [31:0] in_vertex_z = '0;
  logic out_valid, out_visible;
  logic signed [31:0] out_screen_x, out_screen_y;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  // Camera state mirrored by the predictor.
  logic signed [31:0] cam_x, cam_y, cam_z;
  logic signed [15:0] cyaw, syaw, cpitch, spitch;
  logic [15:0] focal;

  vertex_t pending_words[$];
  pixel_t  expected_pixels[$];
  int errors = 0;
  int words_sent = 0;
  int pixels_seen = 0;
  int visible_seen = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  int burst_left = 0;
  bit took = 1'b0;

  vertex_view_project_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_vertex_x(in_vertex_x), .in_vertex_y(in_vertex_y), .in_vertex_z(in_vertex_z),
    .out_valid(out_valid), .out_visible(out_visible),
    .out_screen_x(out_screen_x), .out_screen_y(out_screen_y),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Floor division by 2^14; arithmetic shift of a signed value floors.
  function automatic logic signed [127:0] floor_q14(input logic signed [127:0] v);
    return v >>> TRIG_FRAC;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Project one vertex through the current camera.
  function automatic pixel_t project_vertex(input vertex_t w);
    logic signed [127:0] dx, dy, dz, xr, zr, yf, zf, nx, ny;
    pixel_t p;
    dx = 128'(w.vx) - 128'(cam_x);
    dy = 128'(w.vy) - 128'(cam_y);
    dz = 128'(w.vz) - 128'(cam_z);
    xr = floor_q14(dx * 128'(cyaw) - dz * 128'(syaw));
    zr = floor_q14(dx * 128'(syaw) + dz * 128'(cyaw));
    yf = floor_q14(dy * 128'(cpitch) - zr * 128'(spitch));
    zf = floor_q14(dy * 128'(spitch) + zr * 128'(cpitch));
    p = '0;
    if (zf > 128'sd6554) begin
      nx = xr * $signed({112'd0, focal});
      ny = yf * $signed({112'd0, focal});
      // Signed division in SystemVerilog truncates toward zero.
      p.vis = 1'b1;
      p.sx = clamp32(nx / zf + SCR_W / 2);
      p.sy = clamp32(ny / zf + SCR_H / 2);
    end
    return p;
  endfunction

  // Driver: bursts of words with random gaps, changing at the falling edge.
  always @(negedge clk) begin
    if (took) begin
      void'(pending_words.pop_front());
      words_sent++;
    end
    if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
    end else if (pending_words.size() > 0) begin
      start <= 1'b1;
      in_vertex_x <= pending_words[0].vx;
      in_vertex_y <= pending_words[0].vy;
      in_vertex_z <= pending_words[0].vz;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 30);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
    end else begin
      start <= 1'b0;
    end
  end

  // Predict at acceptance so config state matches the word.
  always @(posedge clk) begin
    took = rst_n && start && !busy;
    if (took) expected_pixels.push_back(project_vertex(pending_words[0]));
  end

  // Monitor: every strobed word is compared with the oldest prediction.
  always @(posedge clk) begin
    pixel_t exp_p;
    if (rst_n && out_valid) begin
      pixels_seen++;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected word vis=%0b x=%0d y=%0d", $time, out_visible,
                 out_screen_x, out_screen_y);
        errors++;
      end else begin
        exp_p = expected_pixels.pop_front();
        if (exp_p.vis) visible_seen++;
        if (out_visible !== exp_p.vis) begin
          $display("%0t: visible expected %0b actual %0b", $time, exp_p.vis, out_visible);
          errors++;
        end
        if (out_screen_x !== exp_p.sx) begin
          $display("%0t: screen_x expected %0d actual %0d", $time, exp_p.sx, out_screen_x);
          errors++;
        end
        if (out_screen_y !== exp_p.sy) begin
          $display("%0t: screen_y expected %0d actual %0d", $time, exp_p.sy, out_screen_y);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted word on either side and no config write.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CAMERA_X:    cam_x = val;
      REG_CAMERA_Y:    cam_y = val;
      REG_CAMERA_Z:    cam_z = val;
      REG_COS_YAW:     cyaw = val[15:0];
      REG_SIN_YAW:     syaw = val[15:0];
      REG_COS_PITCH:   cpitch = val[15:0];
      REG_SIN_PITCH:   spitch = val[15:0];
      REG_FOCAL_SCALE: focal = val[15:0];
      default: ;
    endcase
  endtask

  task automatic queue_vertex(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
    vertex_t w;
    w.vx = x;
    w.vy = y;
    w.vz = z;
    pending_words.push_back(w);
  endtask

  // Drain everything in flight before touching the camera.
  task automatic wait_idle();
    wait (pending_words.size() == 0 && !start);
    wait (expected_pixels.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      2: return 32'($signed($urandom_range(0, 40000000)) - 20000000);
      default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    endcase
  endfunction

  function automatic logic [31:0] rand_trig();
    case ($urandom_range(0, 5))
      0: return 32'($signed($urandom_range(0, 65535)) - 32768);
      1: return 32'sd16384;
      2: return -32'sd16384;
      default: return 32'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  task automatic random_camera();
    write_reg(REG_CAMERA_X, rand_coord());
    write_reg(REG_CAMERA_Y, rand_coord());
    write_reg(REG_CAMERA_Z, ($urandom_range(0, 1) == 0) ? rand_coord()
                            : 32'($signed($urandom_range(0, 10000000)) - 20000000));
    write_reg(REG_COS_YAW, rand_trig());
    write_reg(REG_SIN_YAW, rand_trig());
    write_reg(REG_COS_PITCH, rand_trig());
    write_reg(REG_SIN_PITCH, rand_trig());
    write_reg(REG_FOCAL_SCALE, ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(0, 65535));
  endtask

  initial begin
    int phase;
    cam_x = 32'sd327680;
    cam_y = 32'sd327680;
    cam_z = -32'sd655360;
    cyaw = 16'sd16384;
    syaw = '0;
    cpitch = 16'sd16384;
    spitch = '0;
    focal = 16'd200;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed vertices at reset camera: extremes, near plane edges, overflow.
    queue_vertex(32'sd327680, 32'sd327680, 32'sd0);
    queue_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    queue_vertex(32'h80000000, 32'h80000000, 32'h80000000);
    queue_vertex(32'h7fffffff, 32'h80000000, -32'sd655360 + 32'sd6555);
    queue_vertex(32'h80000000, 32'h7fffffff, -32'sd655360 + 32'sd6554);
    queue_vertex(32'sd0, 32'sd0, -32'sd655360 + 32'sd6553);
    queue_vertex(32'sd0, 32'sd0, -32'sd655360);
    queue_vertex(32'hffffffff, 32'h55555555, 32'haaaaaaaa);
    queue_vertex(32'h55555555, 32'haaaaaaaa, 32'h55555555);
    queue_vertex(32'sd0, 32'sd0, 32'sd0);
    wait_idle();

    // Trig extremes and a zero focal scale.
    write_reg(REG_COS_YAW, 32'hffff8000);
    write_reg(REG_SIN_YAW, 32'h00007fff);
    write_reg(REG_COS_PITCH, 32'hffffc000);
    write_reg(REG_SIN_PITCH, 32'h00004000);
    write_reg(REG_FOCAL_SCALE, 32'd0);
    queue_vertex(32'h7fffffff, 32'h80000000, 32'h80000000);
    queue_vertex(32'h80000000, 32'h7fffffff, 32'h7fffffff);
    queue_vertex(32'sd1000000, -32'sd2000000, -32'sd5000000);
    wait_idle();
    write_reg(REG_FOCAL_SCALE, 32'hffff);
    write_reg(REG_CAMERA_X, 32'h80000000);
    write_reg(REG_CAMERA_Y, 32'h7fffffff);
    write_reg(REG_CAMERA_Z, 32'h80000000);
    queue_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff);
    queue_vertex(32'sd0, 32'sd0, 32'sd0);
    queue_vertex(32'h80000000, 32'h7fffffff, 32'h80000000);
    wait_idle();

    // Random phases, each writing the camera anew: the reset values first, then random ones.
    for (phase = 0; phase < 12; phase++) begin
      if (phase == 0) begin
        write_reg(REG_CAMERA_X, 32'sd327680);
        write_reg(REG_CAMERA_Y, 32'sd327680);
        write_reg(REG_CAMERA_Z, -32'sd655360);
        write_reg(REG_COS_YAW, 32'sd16384);
        write_reg(REG_SIN_YAW, 32'sd0);
        write_reg(REG_COS_PITCH, 32'sd16384);
        write_reg(REG_SIN_PITCH, 32'sd0);
        write_reg(REG_FOCAL_SCALE, 32'd200);
      end else begin
        random_camera();
      end
      repeat (100) queue_vertex(rand_coord(), rand_coord(), rand_coord());
      wait_idle();
    end

    $display("Projected %0d vertices over 15 camera setups; %0d in front of the near plane.",
             pixels_seen, visible_seen);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/vvp_pkg.sv
rtl/vvp_front.sv
rtl/vvp_queue.sv
rtl/vvp_div.sv
rtl/vvp_back.sv
rtl/vertex_view_project_unit.sv
dv/tb_top.sv
